// ===== rtl/stpy_pkg.sv =====
// Package for the stereo triangulator: widths, register codes, status codes,
// the arctangent table and the saturation helpers. No dependencies.
package stpy_pkg;

  localparam int unsigned ANGLE_ITERATIONS_DEF = 16;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned TRIG_W  = 34;
  localparam int unsigned ANG_W   = 28;
  localparam int unsigned NUM_W   = 43;
  localparam int unsigned DEN_W   = 16;
  localparam int unsigned DIV_LAT = 32;
  localparam int unsigned PROD_W  = 68;

  localparam logic [CIDX_W-1:0] REG_WIDTH    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_BASELINE = 3'd2;
  localparam logic [CIDX_W-1:0] REG_FOCAL    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_PITCH    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_YAW      = 3'd5;

  localparam logic [11:0] WIDTH_RST    = 12'd1280;
  localparam logic [11:0] HEIGHT_RST   = 12'd720;
  localparam logic [15:0] BASELINE_RST = 16'd60;
  localparam logic [13:0] FOCAL_RST    = 14'd510;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CENTERED = 2'd1;
  localparam logic [1:0] ST_ZERO_DSP = 2'd2;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [15:0] ANGLE_LIMIT = 16'sd23040;

  typedef enum logic [1:0] {CS_IDLE, CS_PITCH, CS_YAW} cordic_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       negx;
    logic       negy;
    logic       fzero;
  } side_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] k);
    logic signed [ANG_W-1:0] r;
    case (k)
      5'd0:  r = 28'sd2949120;
      5'd1:  r = 28'sd1740967;
      5'd2:  r = 28'sd919879;
      5'd3:  r = 28'sd466945;
      5'd4:  r = 28'sd234379;
      5'd5:  r = 28'sd117304;
      5'd6:  r = 28'sd58666;
      5'd7:  r = 28'sd29335;
      5'd8:  r = 28'sd14668;
      5'd9:  r = 28'sd7334;
      5'd10: r = 28'sd3667;
      5'd11: r = 28'sd1833;
      5'd12: r = 28'sd917;
      5'd13: r = 28'sd458;
      5'd14: r = 28'sd229;
      5'd15: r = 28'sd115;
      5'd16: r = 28'sd57;
      5'd17: r = 28'sd29;
      5'd18: r = 28'sd14;
      5'd19: r = 28'sd7;
      5'd20: r = 28'sd4;
      5'd21: r = 28'sd2;
      5'd22: r = 28'sd1;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] round30(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = (v + (68'sd1 <<< 29)) >>> 30;
    return sat32(t);
  endfunction

  // quotient magnitude (capped at 2^31) to saturated signed value
  function automatic logic signed [OUT_W-1:0] apply_sign(input logic [OUT_W-1:0] q,
                                                          input logic neg);
    logic signed [OUT_W-1:0] r;
    if (neg) begin
      r = $signed(-q);
    end else if (q[OUT_W-1]) begin
      r = 32'sh7FFF_FFFF;
    end else begin
      r = $signed(q);
    end
    return r;
  endfunction

endpackage

// ===== rtl/stpy_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, round to nearest.
// Quotient saturates at 2^31. Uses stpy_pkg.
module stpy_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [stpy_pkg::NUM_W-1:0]     num,
  input  logic [stpy_pkg::DEN_W-1:0]     den,
  output logic [stpy_pkg::OUT_W-1:0]     quo
);

  localparam int unsigned REM_W = stpy_pkg::NUM_W + 1;
  localparam int unsigned QB    = stpy_pkg::OUT_W - 1;
  localparam int unsigned CMP_W = REM_W + 3;

  logic [REM_W-1:0]              rem [0:QB];
  logic [stpy_pkg::DEN_W-1:0]    dv  [0:QB];
  logic [QB-1:0]                 q   [0:QB];
  logic                          ovf [0:QB];
  logic [REM_W-1:0]              rem_init;

  assign rem_init = {1'b0, num} + REM_W'(den >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= rem_init;
      dv[0]  <= den;
      q[0]   <= '0;
      ovf[0] <= {3'b0, rem_init[REM_W-1:QB]} >= den;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int unsigned B = QB - 1 - s;
    logic [CMP_W-1:0] shifted;
    logic             ge;

    assign shifted = CMP_W'(dv[s]) << B;
    assign ge      = CMP_W'(rem[s]) >= shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? rem[s] - shifted[REM_W-1:0] : rem[s];
        q[s+1]   <= q[s] | (QB'(ge) << B);
        dv[s+1]  <= dv[s];
        ovf[s+1] <= ovf[s];
      end
    end
  end

  assign quo = ovf[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q[QB]};

endmodule

// ===== rtl/stereo_triangulate_pitch_yaw.sv =====
// Stereo triangulation with pitch and yaw rotation. Uses stpy_pkg, stpy_div.
// One word per cycle is sustained while in_stall is low (no out_stall and CORDIC idle),
// set by the 32-stage divider pipeline. After reset and after each angle write the
// CORDIC unit computes the pitch and then the yaw sine/cosine, with in_stall high.
// Reset clears all valid bits and loads the default register values.
module stereo_triangulate_pitch_yaw #(
  parameter int unsigned ANGLE_ITERATIONS = stpy_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_en,
  input  logic [stpy_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [stpy_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [stpy_pkg::PIX_W-1:0]          left_x,
  input  logic [stpy_pkg::PIX_W-1:0]          left_y,
  input  logic [stpy_pkg::PIX_W-1:0]          right_x,
  input  logic [stpy_pkg::PIX_W-1:0]          right_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [stpy_pkg::OUT_W-1:0]   depth_z,
  output logic signed [stpy_pkg::OUT_W-1:0]   lateral_x,
  output logic [1:0]                          status
);

  localparam int unsigned IT_W   = (ANGLE_ITERATIONS > 1) ? $clog2(ANGLE_ITERATIONS) : 1;
  localparam int unsigned TW     = stpy_pkg::TRIG_W;
  localparam int unsigned AW     = stpy_pkg::ANG_W;
  localparam int unsigned OW     = stpy_pkg::OUT_W;
  localparam int unsigned PW     = stpy_pkg::PROD_W;
  localparam int unsigned LAT    = stpy_pkg::DIV_LAT;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(ANGLE_ITERATIONS - 1);

  // configuration
  logic [11:0]        image_width, image_height;
  logic [15:0]        baseline_length;
  logic [13:0]        focal_length_px;
  logic signed [15:0] pitch_angle, yaw_angle;
  logic               ang_write;

  assign ang_write = cfg_en && (cfg_index == stpy_pkg::REG_PITCH ||
                                cfg_index == stpy_pkg::REG_YAW);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= stpy_pkg::WIDTH_RST;
      image_height    <= stpy_pkg::HEIGHT_RST;
      baseline_length <= stpy_pkg::BASELINE_RST;
      focal_length_px <= stpy_pkg::FOCAL_RST;
      pitch_angle     <= '0;
      yaw_angle       <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        stpy_pkg::REG_WIDTH:    image_width     <= cfg_data[11:0];
        stpy_pkg::REG_HEIGHT:   image_height    <= cfg_data[11:0];
        stpy_pkg::REG_BASELINE: baseline_length <= cfg_data;
        stpy_pkg::REG_FOCAL:    focal_length_px <= cfg_data[13:0];
        stpy_pkg::REG_PITCH:    pitch_angle     <= $signed(cfg_data);
        stpy_pkg::REG_YAW:      yaw_angle       <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // CORDIC sine/cosine, shared by pitch and yaw
  stpy_pkg::cordic_state_t cstate, cstate_next;
  logic                    cload, cload_next;
  logic [IT_W-1:0]         iter;
  logic signed [TW-1:0]    cx_r, cy_r, cx_step, cy_step;
  logic signed [AW-1:0]    cz_r, cz_step;
  logic signed [TW-1:0]    cp, sp, cw, sw;
  logic signed [15:0]      pitch_cl, yaw_cl;
  logic                    busy, last_iter;

  function automatic logic signed [15:0] clamp_ang(input logic signed [15:0] a);
    logic signed [15:0] r;
    if (a > stpy_pkg::ANGLE_LIMIT) begin
      r = stpy_pkg::ANGLE_LIMIT;
    end else if (a < -stpy_pkg::ANGLE_LIMIT) begin
      r = -stpy_pkg::ANGLE_LIMIT;
    end else begin
      r = a;
    end
    return r;
  endfunction

  assign pitch_cl  = clamp_ang(pitch_angle);
  assign yaw_cl    = clamp_ang(yaw_angle);
  assign busy      = cstate != stpy_pkg::CS_IDLE;
  assign last_iter = iter == IT_LAST;

  always_comb begin
    if (!cz_r[AW-1]) begin
      cx_step = cx_r - (cy_r >>> iter);
      cy_step = cy_r + (cx_r >>> iter);
      cz_step = cz_r - stpy_pkg::atan_q16(5'(iter));
    end else begin
      cx_step = cx_r + (cy_r >>> iter);
      cy_step = cy_r - (cx_r >>> iter);
      cz_step = cz_r + stpy_pkg::atan_q16(5'(iter));
    end
  end

  always_comb begin
    cstate_next = cstate;
    cload_next  = 1'b0;
    if (ang_write) begin
      cstate_next = stpy_pkg::CS_PITCH;
      cload_next  = 1'b1;
    end else if (!cload && last_iter) begin
      case (cstate)
        stpy_pkg::CS_PITCH: cstate_next = stpy_pkg::CS_YAW;
        stpy_pkg::CS_YAW:   cstate_next = stpy_pkg::CS_IDLE;
        default:            cstate_next = cstate;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= stpy_pkg::CS_PITCH;
      cload  <= 1'b1;
    end else begin
      cstate <= cstate_next;
      cload  <= cload_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cload) begin
      cx_r <= stpy_pkg::CORDIC_GAIN;
      cy_r <= '0;
      cz_r <= AW'($signed({pitch_cl, 8'b0}));
      iter <= '0;
    end else if (busy) begin
      if (last_iter) begin
        cx_r <= stpy_pkg::CORDIC_GAIN;
        cy_r <= '0;
        cz_r <= AW'($signed({yaw_cl, 8'b0}));
        iter <= '0;
        if (cstate == stpy_pkg::CS_PITCH) begin
          cp <= cx_step;
          sp <= cy_step;
        end else begin
          cw <= cx_step;
          sw <= cy_step;
        end
      end else begin
        cx_r <= cx_step;
        cy_r <= cy_step;
        cz_r <= cz_step;
        iter <= iter + 1'b1;
      end
    end
  end

  // pipeline advance
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en || busy;

  // stage A: offsets
  logic [14:0]        cxc, cyc;
  logic signed [17:0] dl, dr;
  logic signed [16:0] den;
  logic signed [18:0] m;
  logic               a_valid;
  logic [1:0]         a_status;
  logic [15:0]        a_adl, a_aden;
  logic [16:0]        a_am;
  logic               a_negdl, a_negden, a_negm;
  logic [17:0]        dl_abs;
  logic [16:0]        den_abs;
  logic [18:0]        m_abs;

  assign cxc     = {image_width[11:1], 4'b0};
  assign cyc     = {image_height[11:1], 4'b0};
  assign dl      = $signed({3'b0, cxc}) - $signed({2'b0, left_x});
  assign dr      = $signed({3'b0, cxc}) - $signed({2'b0, right_x});
  assign den     = $signed({1'b0, right_x}) - $signed({1'b0, left_x});
  assign m       = $signed({3'b0, cyc, 1'b0}) - $signed({3'b0, left_y})
                   - $signed({3'b0, right_y});
  assign dl_abs  = dl[17] ? 18'(-dl) : 18'(dl);
  assign den_abs = den[16] ? 17'(-den) : 17'(den);
  assign m_abs   = m[18] ? 19'(-m) : 19'(m);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dl == 0 && dr == 0) begin
        a_status <= stpy_pkg::ST_CENTERED;
      end else if (den == 0) begin
        a_status <= stpy_pkg::ST_ZERO_DSP;
      end else begin
        a_status <= stpy_pkg::ST_OK;
      end
      a_adl    <= dl_abs[15:0];
      a_aden   <= den_abs[15:0];
      a_am     <= m_abs[16:0];
      a_negdl  <= dl[17];
      a_negden <= den[16];
      a_negm   <= m[18];
    end
  end

  // stage B: numerator products
  stpy_pkg::side_t b_side;
  logic [31:0] b_px;
  logic [29:0] b_pz;
  logic [32:0] b_py;
  logic [15:0] b_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_side.valid <= 1'b0;
    end else if (en) begin
      b_side.valid <= a_valid;
    end
    if (en) begin
      b_side.status <= a_status;
      b_side.negx   <= a_negdl ^ a_negden;
      b_side.negy   <= a_negm;
      b_side.fzero  <= focal_length_px == '0;
      b_px          <= baseline_length * a_adl;
      b_pz          <= baseline_length * focal_length_px;
      b_py          <= baseline_length * a_am;
      b_den         <= a_aden;
    end
  end

  // dividers
  logic [OW-1:0] qx, qz, qy;

  stpy_div u_div_x (.clk(clk), .en(en),
    .num(stpy_pkg::NUM_W'({b_px, 8'b0})),  .den(b_den), .quo(qx));
  stpy_div u_div_z (.clk(clk), .en(en),
    .num(stpy_pkg::NUM_W'({b_pz, 12'b0})), .den(b_den), .quo(qz));
  stpy_div u_div_y (.clk(clk), .en(en),
    .num(stpy_pkg::NUM_W'({b_py, 7'b0})),  .den(b_den), .quo(qy));

  stpy_pkg::side_t d_side [0:LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        d_side[i].valid <= 1'b0;
      end
    end else if (en) begin
      d_side[0].valid <= b_side.valid;
      for (int i = 1; i < LAT; i++) begin
        d_side[i].valid <= d_side[i-1].valid;
      end
    end
    if (en) begin
      d_side[0].status <= b_side.status;
      d_side[0].negx   <= b_side.negx;
      d_side[0].negy   <= b_side.negy;
      d_side[0].fzero  <= b_side.fzero;
      for (int i = 1; i < LAT; i++) begin
        d_side[i].status <= d_side[i-1].status;
        d_side[i].negx   <= d_side[i-1].negx;
        d_side[i].negy   <= d_side[i-1].negy;
        d_side[i].fzero  <= d_side[i-1].fzero;
      end
    end
  end

  // stage C: sign and saturate
  logic               c_valid;
  logic [1:0]         c_status;
  logic signed [OW-1:0] c_x, c_y, c_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= d_side[LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_status <= d_side[LAT-1].status;
      c_x      <= stpy_pkg::apply_sign(qx, d_side[LAT-1].negx);
      c_z      <= stpy_pkg::apply_sign(qz, 1'b0);
      c_y      <= d_side[LAT-1].fzero ? '0 : stpy_pkg::apply_sign(qy, d_side[LAT-1].negy);
    end
  end

  // rotation stages
  logic                 m1_valid, m2_valid, m3_valid, m4_valid;
  logic [1:0]           m1_status, m2_status, m3_status, m4_status;
  logic signed [OW-1:0] m1_x, m2_x;
  logic signed [PW-3:0] m1_pz, m1_py;
  logic signed [OW-1:0] m2_z1;
  logic signed [PW-3:0] m3_a, m3_b, m3_c, m3_d;
  logic signed [OW-1:0] m4_zo, m4_xo;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid  <= 1'b0;
      m2_valid  <= 1'b0;
      m3_valid  <= 1'b0;
      m4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m1_valid  <= c_valid;
      m2_valid  <= m1_valid;
      m3_valid  <= m2_valid;
      m4_valid  <= m3_valid;
      out_valid <= m4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_status <= c_status;
      m1_x      <= c_x;
      m1_pz     <= c_z * cp;
      m1_py     <= c_y * sp;

      m2_status <= m1_status;
      m2_x      <= m1_x;
      m2_z1     <= stpy_pkg::round30(PW'(m1_pz) + PW'(m1_py));

      m3_status <= m2_status;
      m3_a      <= m2_z1 * cw;
      m3_b      <= m2_x * sw;
      m3_c      <= m2_x * cw;
      m3_d      <= m2_z1 * sw;

      m4_status <= m3_status;
      m4_zo     <= stpy_pkg::round30(PW'(m3_a) - PW'(m3_b));
      m4_xo     <= stpy_pkg::round30(PW'(m3_c) + PW'(m3_d));

      status    <= m4_status;
      if (m4_status == stpy_pkg::ST_OK) begin
        depth_z   <= m4_zo;
        lateral_x <= m4_xo;
      end else begin
        depth_z   <= '0;
        lateral_x <= '0;
      end
    end
  end

endmodule
